>>> rtl/core/prefix_code_bit_decoder_core_defines.svh
// Assertion macros shared by the prefix code bit decoder RTL.
`ifndef PREFIX_CODE_BIT_DECODER_CORE_DEFINES_SVH
`define PREFIX_CODE_BIT_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define PCBD_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcbd: implication check failed");

`define PCBD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcbd: next-cycle check failed");

`else

`define PCBD_ASSERT_IMPLY(label, ante, cons)

`define PCBD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/pcbd_pkg.sv
// Package: constants, codes and types of the prefix code bit decoder.
`default_nettype none

package pcbd_pkg;

   localparam int MAX_CODES  = 128;
   localparam int CODE_BITS  = 8;
   localparam int BYTE_BITS  = 8;
   localparam int IDX_W      = $clog2(MAX_CODES);
   localparam int CNT_W      = $clog2(MAX_CODES + 1);
   localparam int OFF_W      = $clog2(CODE_BITS);
   localparam int BIT_W      = $clog2(BYTE_BITS);
   localparam int SYM_W      = 7;
   localparam int USED_W     = 8;
   localparam int TOTAL_W    = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_DECODE  = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_USED_CODES    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_SYMBOLS = 1'd1;

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic [SYM_W-1:0]     symbol;
   } entry_type;

   typedef struct packed {
      logic                 start;
      logic [CODE_BITS-1:0] key;
      logic [CODE_BITS-1:0] mask;
   } scan_req_type;

   typedef struct packed {
      logic             done;
      logic             one_hit;
      logic [SYM_W-1:0] symbol;
   } scan_rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/pcbd_scan.sv
// Code table memory with a shared compare unit that walks the used entries.
`default_nettype none
`include "prefix_code_bit_decoder_core_defines.svh"

module pcbd_scan import pcbd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  entry_type          wr_entry,
   input  logic [CNT_W-1:0]   count,
   input  scan_req_type       scan_req,
   output scan_rsp_type       scan_rsp
);

   entry_type            entry_mem_ff [MAX_CODES];
   entry_type            rd_entry_ff;
   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic                 any_hit_ff, any_hit_in;
   logic                 multi_hit_ff, multi_hit_in;
   logic [SYM_W-1:0]     symbol_ff, symbol_in;
   logic [CODE_BITS-1:0] key_ff, key_in;
   logic [CODE_BITS-1:0] mask_ff, mask_in;
   logic                 issue_more;
   logic                 match;
   logic                 done;

   assign issue_more = busy_ff && (issue_ff != count);
   assign match      = ((rd_entry_ff.code ^ key_ff) & mask_ff) == '0;
   assign done       = busy_ff && !issue_more && !rd_valid_ff;

   always_comb begin
      busy_in      = busy_ff;
      issue_in     = issue_ff;
      rd_valid_in  = rd_valid_ff;
      any_hit_in   = any_hit_ff;
      multi_hit_in = multi_hit_ff;
      symbol_in    = symbol_ff;
      key_in       = key_ff;
      mask_in      = mask_ff;
      if (scan_req.start) begin
         busy_in      = 1'b1;
         issue_in     = '0;
         rd_valid_in  = 1'b0;
         any_hit_in   = 1'b0;
         multi_hit_in = 1'b0;
         key_in       = scan_req.key;
         mask_in      = scan_req.mask;
      end else begin
         rd_valid_in = issue_more;
         if (issue_more) begin
            issue_in = issue_ff + 1'b1;
         end
         if (rd_valid_ff && match) begin
            if (any_hit_ff) begin
               multi_hit_in = 1'b1;
            end else begin
               any_hit_in = 1'b1;
               symbol_in  = rd_entry_ff.symbol;
            end
         end
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         any_hit_ff   <= 1'b0;
         multi_hit_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         any_hit_ff   <= any_hit_in;
         multi_hit_ff <= multi_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff <= symbol_in;
      key_ff    <= key_in;
      mask_ff   <= mask_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_entry;
      end
      if (issue_more) begin
         rd_entry_ff <= entry_mem_ff[issue_ff[IDX_W-1:0]];
      end
   end

   assign scan_rsp.done    = done;
   assign scan_rsp.one_hit = any_hit_ff && !multi_hit_ff;
   assign scan_rsp.symbol  = symbol_ff;

   `PCBD_ASSERT_IMPLY(a_read_while_busy, rd_valid_ff, busy_ff)
   `PCBD_ASSERT_NEXT(a_done_goes_idle, done && !scan_req.start, !busy_ff)
   `PCBD_ASSERT_IMPLY(a_start_when_idle, scan_req.start, !busy_ff)
   `PCBD_ASSERT_IMPLY(a_multi_needs_any, multi_hit_ff, any_hit_ff)

endmodule

`default_nettype wire

>>> rtl/core/prefix_code_bit_decoder_core.sv
// Top level: bit sequencer, configuration registers and result staging.
`default_nettype none
`include "prefix_code_bit_decoder_core_defines.svh"

// Prefix code bit decoder. A decode item walks its byte one bit at a time; each bit
// reads the first min(used_codes, 128) table entries one per cycle through a single
// memory port and compare unit. Results pass through a one-deep hold stage (to mark
// the last result of a byte) and an output register; a stalled output slows the
// sequencer only when both are full. New items are taken only between bytes.
module prefix_code_bit_decoder_core import pcbd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [6:0]            req_entry_index,
   input  logic [7:0]            req_entry_code,
   input  logic [SYM_W-1:0]      req_entry_symbol,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_final_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SYM_W-1:0]      rsp_symbol,
   output logic                  rsp_code_error,
   output logic                  rsp_last_of_item,
   output logic                  rsp_string_done
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_BIT    = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_RESULT = 3'd3;
   localparam logic [2:0] S_FLUSH  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [USED_W-1:0]    used_codes_ff, used_codes_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [TOTAL_W-1:0]   emitted_ff, emitted_in;
   logic [CODE_BITS-1:0] acc_ff, acc_in;
   logic [OFF_W-1:0]     offset_ff, offset_in;
   logic [BYTE_BITS-1:0] byte_ff, byte_in;
   logic                 fin_ff, fin_in;
   logic [BIT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic                 hold_valid_ff, hold_valid_in;
   logic [SYM_W-1:0]     hold_symbol_ff, hold_symbol_in;
   logic                 hold_error_ff, hold_error_in;
   logic                 hold_done_ff, hold_done_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]     rsp_symbol_ff, rsp_symbol_in;
   logic                 rsp_error_ff, rsp_error_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_done_ff, rsp_done_in;

   scan_req_type         scan_req;
   scan_rsp_type         scan_rsp;
   entry_type            wr_entry;
   logic                 wr_en;
   logic [CNT_W-1:0]     ncmp;
   logic [CODE_BITS-1:0] acc_next;
   logic [CODE_BITS-1:0] bit_mask;
   logic [TOTAL_W-1:0]   emitted_inc;
   logic                 out_free;
   logic                 last_offset;
   logic                 emit;

   assign ncmp        = (32'(used_codes_ff) > MAX_CODES) ? CNT_W'(MAX_CODES)
                                                         : CNT_W'(used_codes_ff);
   assign acc_next    = acc_ff | (CODE_BITS'(byte_ff[bit_cnt_ff]) << offset_ff);
   assign bit_mask    = ~({CODE_BITS{1'b1}} << ((OFF_W + 1)'(offset_ff) + 1'b1));
   assign emitted_inc = emitted_ff + 1'b1;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign last_offset = offset_ff == OFF_W'(CODE_BITS - 1);
   assign emit        = scan_rsp.one_hit || last_offset;

   assign wr_en           = (state_ff == S_IDLE) && req_valid && (req_opcode == OP_LOAD)
                            && (32'(req_entry_index) < MAX_CODES);
   assign wr_entry.code   = CODE_BITS'(req_entry_code);
   assign wr_entry.symbol = req_entry_symbol;

   assign scan_req.start = (state_ff == S_BIT) && (emitted_ff < total_ff);
   assign scan_req.key   = acc_next;
   assign scan_req.mask  = bit_mask;

   pcbd_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (IDX_W'(req_entry_index)),
      .wr_entry (wr_entry),
      .count    (ncmp),
      .scan_req (scan_req),
      .scan_rsp (scan_rsp)
   );

   always_comb begin
      state_in       = state_ff;
      used_codes_in  = used_codes_ff;
      total_in       = total_ff;
      emitted_in     = emitted_ff;
      acc_in         = acc_ff;
      offset_in      = offset_ff;
      byte_in        = byte_ff;
      fin_in         = fin_ff;
      bit_cnt_in     = bit_cnt_ff;
      hold_valid_in  = hold_valid_ff;
      hold_symbol_in = hold_symbol_ff;
      hold_error_in  = hold_error_ff;
      hold_done_in   = hold_done_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_symbol_in  = rsp_symbol_ff;
      rsp_error_in   = rsp_error_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_done_in    = rsp_done_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_USED_CODES:    used_codes_in = USED_W'(csr_write_data);
            CSR_TOTAL_SYMBOLS: total_in      = TOTAL_W'(csr_write_data);
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  OP_DECODE: begin
                     byte_in    = req_data_byte;
                     fin_in     = req_final_byte;
                     bit_cnt_in = '0;
                     state_in   = S_BIT;
                  end
                  OP_RESTART: begin
                     acc_in     = '0;
                     offset_in  = '0;
                     emitted_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_BIT: begin
            if (emitted_ff >= total_ff) begin
               state_in = S_FLUSH;
            end else begin
               acc_in   = acc_next;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_rsp.done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!(emit && hold_valid_ff && !out_free)) begin
               if (emit) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_symbol_in = hold_symbol_ff;
                     rsp_error_in  = hold_error_ff;
                     rsp_done_in   = hold_done_ff;
                     rsp_last_in   = 1'b0;
                  end
                  hold_valid_in  = 1'b1;
                  hold_symbol_in = scan_rsp.one_hit ? scan_rsp.symbol : '0;
                  hold_error_in  = !scan_rsp.one_hit;
                  hold_done_in   = scan_rsp.one_hit && (emitted_inc == total_ff);
                  if (scan_rsp.one_hit) begin
                     emitted_in = emitted_inc;
                  end
                  acc_in    = '0;
                  offset_in = '0;
               end else begin
                  offset_in = offset_ff + 1'b1;
               end
               if (bit_cnt_ff == BIT_W'(BYTE_BITS - 1)) begin
                  state_in = S_FLUSH;
               end else begin
                  bit_cnt_in = bit_cnt_ff + 1'b1;
                  state_in   = S_BIT;
               end
            end
         end
         S_FLUSH: begin
            if (!(hold_valid_ff && !out_free)) begin
               if (hold_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_symbol_in = hold_symbol_ff;
                  rsp_error_in  = hold_error_ff;
                  rsp_done_in   = hold_done_ff;
                  rsp_last_in   = 1'b1;
                  hold_valid_in = 1'b0;
               end
               if (fin_ff) begin
                  acc_in    = '0;
                  offset_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_codes_ff <= USED_W'(1);
         total_ff      <= '0;
         emitted_ff    <= '0;
         acc_ff        <= '0;
         offset_ff     <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_codes_ff <= used_codes_in;
         total_ff      <= total_in;
         emitted_ff    <= emitted_in;
         acc_ff        <= acc_in;
         offset_ff     <= offset_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff        <= byte_in;
      fin_ff         <= fin_in;
      bit_cnt_ff     <= bit_cnt_in;
      hold_symbol_ff <= hold_symbol_in;
      hold_error_ff  <= hold_error_in;
      hold_done_ff   <= hold_done_in;
      rsp_symbol_ff  <= rsp_symbol_in;
      rsp_error_ff   <= rsp_error_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_done_ff    <= rsp_done_in;
   end

   assign req_ready        = state_ff == S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol       = rsp_symbol_ff;
   assign rsp_code_error   = rsp_error_ff;
   assign rsp_last_of_item = rsp_last_ff;
   assign rsp_string_done  = rsp_done_ff;

   `PCBD_ASSERT_IMPLY(a_idle_hold_empty, req_ready, !hold_valid_ff)
   `PCBD_ASSERT_IMPLY(a_error_beat_clean, rsp_valid && rsp_code_error,
                      !rsp_string_done && rsp_symbol == '0)
   `PCBD_ASSERT_NEXT(a_scan_to_result, state_ff == S_SCAN && scan_rsp.done, state_ff == S_RESULT)

endmodule

`default_nettype wire

>>> verif/symbol_stream_checker.sv
// Checker for the prefix code bit decoder: predicts every result beat and compares it.
`timescale 1ns / 1ps

module symbol_stream_checker import pcbd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [6:0]            req_entry_index,
   input  logic [7:0]            req_entry_code,
   input  logic [SYM_W-1:0]      req_entry_symbol,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_final_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [SYM_W-1:0]      rsp_symbol,
   input  logic                  rsp_code_error,
   input  logic                  rsp_last_of_item,
   input  logic                  rsp_string_done,
   output int                    fail_count,
   output int                    outstanding
);

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             code_error;
      logic             last_of_item;
      logic             string_done;
   } symbol_beat_type;

   logic [CODE_BITS-1:0] code_mem [MAX_CODES];
   logic [SYM_W-1:0]     symbol_mem [MAX_CODES];
   logic [CODE_BITS-1:0] accum;
   logic [OFF_W-1:0]     offset;
   logic [TOTAL_W-1:0]   emitted;
   logic [USED_W-1:0]    used_codes;
   logic [TOTAL_W-1:0]   total_symbols;
   symbol_beat_type      expected_symbols [$];

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : model
      symbol_beat_type      want;
      symbol_beat_type      batch [BYTE_BITS];
      logic [CODE_BITS-1:0] mask;
      int                   n, hits, hit_idx, ncmp, depth;
      if (reset) begin
         for (int i = 0; i < MAX_CODES; i++) begin
            code_mem[i] = '0;
            symbol_mem[i] = '0;
         end
         accum = '0;
         offset = '0;
         emitted = '0;
         used_codes = USED_W'(1);
         total_symbols = '0;
         expected_symbols.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_symbols.size() == 0) begin
               $error("unexpected result beat: symbol %0d code_error %0b",
                      rsp_symbol, rsp_code_error);
               fail_count++;
            end else begin
               want = expected_symbols.pop_front();
               check_field("symbol", 8'(want.symbol), 8'(rsp_symbol));
               check_field("code_error", 8'(want.code_error), 8'(rsp_code_error));
               check_field("last_of_item", 8'(want.last_of_item), 8'(rsp_last_of_item));
               check_field("string_done", 8'(want.string_done), 8'(rsp_string_done));
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_USED_CODES:    used_codes = csr_write_data[USED_W-1:0];
               CSR_TOTAL_SYMBOLS: total_symbols = csr_write_data[TOTAL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_opcode)
               OP_LOAD: begin
                  code_mem[req_entry_index] = req_entry_code;
                  symbol_mem[req_entry_index] = req_entry_symbol;
               end
               OP_RESTART: begin
                  accum = '0;
                  offset = '0;
                  emitted = '0;
               end
               OP_DECODE: begin
                  n = 0;
                  ncmp = (used_codes > MAX_CODES) ? MAX_CODES : int'(used_codes);
                  for (int b = 0; b < BYTE_BITS; b++) begin
                     if (emitted >= total_symbols) break;
                     accum[offset] = req_data_byte[b];
                     depth = int'(offset) + 1;
                     mask = CODE_BITS'((1 << depth) - 1);
                     hits = 0;
                     hit_idx = 0;
                     for (int i = 0; i < ncmp; i++) begin
                        if (((code_mem[i] ^ accum) & mask) == '0) begin
                           if (hits == 0) hit_idx = i;
                           hits++;
                        end
                     end
                     if (hits == 1) begin
                        emitted = emitted + 1'b1;
                        batch[n] = '{symbol: symbol_mem[hit_idx], code_error: 1'b0,
                                     last_of_item: 1'b0,
                                     string_done: (emitted == total_symbols)};
                        n++;
                        accum = '0;
                        offset = '0;
                     end else if (depth >= CODE_BITS) begin
                        batch[n] = '{symbol: '0, code_error: 1'b1, last_of_item: 1'b0,
                                     string_done: 1'b0};
                        n++;
                        accum = '0;
                        offset = '0;
                     end else begin
                        offset = offset + 1'b1;
                     end
                  end
                  // leftover bits of the last byte are dropped
                  if (req_final_byte) begin
                     accum = '0;
                     offset = '0;
                  end
                  if (n > 0) batch[n-1].last_of_item = 1'b1;
                  for (int k = 0; k < n; k++) expected_symbols.push_back(batch[k]);
               end
               default: ;
            endcase
         end
      end
      outstanding <= expected_symbols.size();
   end

endmodule

>>> verif/prefix_code_bit_decoder_core_test.sv
// Testbench top for the prefix code bit decoder: code tables, encoded strings, verdict.
`timescale 1ns / 1ps

module prefix_code_bit_decoder_core_test;
   import pcbd_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 1100;
   localparam int LONG_HOLD = 600;
   localparam int PHASES = 6;
   localparam int USED_PLAN [PHASES] = '{2, 6, 1, 128, 255, 3};
   localparam int TOTAL_PLAN [PHASES] = '{6, 12, 4, 9, 7, 16777215};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_opcode = OP_LOAD;
   logic [6:0]            req_entry_index = '0;
   logic [7:0]            req_entry_code = '0;
   logic [SYM_W-1:0]      req_entry_symbol = '0;
   logic [7:0]            req_data_byte = '0;
   logic                  req_final_byte = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [SYM_W-1:0]      rsp_symbol;
   logic                  rsp_code_error;
   logic                  rsp_last_of_item;
   logic                  rsp_string_done;
   int                    fail_count;
   int                    outstanding;

   // codewords of the table currently loaded, as used by the encoder
   logic [CODE_BITS-1:0]  leaf_code [MAX_CODES];
   int                    leaf_len [MAX_CODES];
   bit                    stream_bits [$];
   int                    sent_beats = 0;
   int                    taken_beats = 0;

   always #1 clock = ~clock;

   prefix_code_bit_decoder_core u_top (.*);

   symbol_stream_checker u_check (.*);

   task automatic send_item(input logic [1:0] opcode, input logic [6:0] index,
                            input logic [7:0] code, input logic [SYM_W-1:0] sym,
                            input logic [7:0] data, input logic fin);
      int gap;
      gap = (sent_beats % 40 < 10) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= opcode;
      req_entry_index <= index;
      req_entry_code <= code;
      req_entry_symbol <= sym;
      req_data_byte <= data;
      req_final_byte <= fin;
      do @(posedge clock); while (!req_ready);
      sent_beats++;
   endtask

   task automatic load_entry(input int index, input logic [7:0] code,
                             input logic [SYM_W-1:0] sym);
      send_item(OP_LOAD, 7'(index), code, sym, 8'($urandom), 1'($urandom));
   endtask

   task automatic decode_byte(input logic [7:0] data, input logic fin);
      send_item(OP_DECODE, 7'($urandom), 8'($urandom), SYM_W'($urandom), data, fin);
   endtask

   task automatic restart_string();
      send_item(OP_RESTART, 7'($urandom), 8'($urandom), SYM_W'($urandom),
                8'($urandom), 1'($urandom));
   endtask

   task automatic set_config(input int used, input int total);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // a byte with no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= CSR_USED_CODES;
      csr_write_data <= CSR_DATA_W'(used);
      @(posedge clock);
      csr_index <= CSR_TOTAL_SYMBOLS;
      csr_write_data <= CSR_DATA_W'(total);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // random full binary tree, depth at most CODE_BITS, loaded as entries 0..n-1
   task automatic load_code_tree(input int n);
      int count, pick, len;
      logic [CODE_BITS-1:0] low_mask;
      leaf_code[0] = CODE_BITS'($urandom_range(0, 1));
      leaf_len[0] = 1;
      if (n >= 2) begin
         leaf_code[0] = '0;
         leaf_code[1] = CODE_BITS'(1);
         leaf_len[1] = 1;
         count = 2;
         while (count < n) begin
            do pick = $urandom_range(0, count - 1); while (leaf_len[pick] >= CODE_BITS);
            len = leaf_len[pick];
            leaf_code[count] = leaf_code[pick] | (CODE_BITS'(1) << len);
            leaf_len[count] = len + 1;
            leaf_len[pick] = len + 1;
            count++;
         end
      end
      for (int i = 0; i < n; i++) begin
         low_mask = CODE_BITS'((1 << leaf_len[i]) - 1);
         leaf_code[i] = (leaf_code[i] & low_mask) | (CODE_BITS'($urandom) & ~low_mask);
         load_entry(i, leaf_code[i], SYM_W'($urandom));
      end
   endtask

   task automatic send_string(input int n, input int nsym, input bit corrupt,
                              input bit open_end);
      int e, pos;
      logic [7:0] data;
      stream_bits.delete();
      for (int s = 0; s < nsym; s++) begin
         e = $urandom_range(0, n - 1);
         for (int b = 0; b < leaf_len[e]; b++) stream_bits.push_back(leaf_code[e][b]);
      end
      if (corrupt) begin
         pos = $urandom_range(0, stream_bits.size() - 1);
         stream_bits[pos] = ~stream_bits[pos];
      end
      while (stream_bits.size() > 0) begin
         data = 8'($urandom);
         for (int b = 0; b < BYTE_BITS && stream_bits.size() > 0; b++)
            data[b] = stream_bits.pop_front();
         decode_byte(data, stream_bits.size() == 0 && !open_end);
      end
   endtask

   initial begin
      int n, total, nsym, start_beats, budget;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one entry compared, nothing to decode
      load_entry(0, 8'h00, 7'd127);
      decode_byte(8'hFF, 1'b1);
      send_item(OP_UNUSED, 7'd127, 8'hFF, 7'd127, 8'hFF, 1'b1);
      restart_string();

      // codes 0, 10, 11 (first bit lowest)
      set_config(3, 16777215);
      load_entry(0, 8'h00, 7'd0);
      load_entry(1, 8'h01, 7'd127);
      load_entry(2, 8'hFF, 7'd85);
      load_entry(127, 8'hFF, 7'd127);
      decode_byte(8'h00, 1'b0);
      decode_byte(8'hFF, 1'b0);
      decode_byte(8'h80, 1'b1);
      decode_byte(8'h00, 1'b0);
      // entry 1 now shares the prefix of entry 0: zeros never resolve
      load_entry(1, 8'h00, 7'd42);
      decode_byte(8'h00, 1'b0);
      decode_byte(8'h01, 1'b1);
      restart_string();

      set_config(0, 5);
      decode_byte(8'h5A, 1'b0);

      set_config(2, 1);
      load_entry(1, 8'h81, 7'd3);
      decode_byte(8'h00, 1'b0);
      decode_byte(8'hFF, 1'b1);
      restart_string();
      decode_byte(8'h02, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         total = TOTAL_PLAN[p];
         n = (USED_PLAN[p] > MAX_CODES) ? MAX_CODES : USED_PLAN[p];
         set_config(USED_PLAN[p], total);
         if (USED_PLAN[p] <= MAX_CODES) load_code_tree(n);
         budget = (n >= MAX_CODES) ? 2 : 3;
         start_beats = sent_beats;
         while (sent_beats - start_beats < budget) begin
            case ($urandom_range(0, 9))
               0: decode_byte(8'($urandom), 1'($urandom));
               1: begin
                  if (n < MAX_CODES && $urandom_range(0, 1))
                     load_entry($urandom_range(n, MAX_CODES - 1), 8'($urandom),
                                SYM_W'($urandom));
                  else
                     send_item(OP_UNUSED, 7'($urandom), 8'($urandom), SYM_W'($urandom),
                               8'($urandom), 1'($urandom));
               end
               2: restart_string();
               default: begin
                  restart_string();
                  if (total > 64) nsym = $urandom_range(3, 12);
                  else nsym = total + $urandom_range(0, 4) - 2;
                  if (nsym < 1) nsym = 1;
                  send_string(n, nsym, $urandom_range(0, 5) == 0, $urandom_range(0, 7) == 0);
               end
            endcase
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // result side; one long hold-off lets the decoder back up into its input
   initial begin
      int hold;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         hold = (taken_beats % 48 < 12) ? 0 : $urandom_range(0, 4);
         if (taken_beats == 40) hold = LONG_HOLD;
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken_beats++;
      end
   end

   initial begin
      #1000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
